@@ design/darg_pkg.sv @@
package darg_pkg;

  // largest process count a safe sequence can carry
  localparam int unsigned MaxSeq = 8;
  // work sums: free units plus the held units of up to eight processes
  localparam int unsigned WorkW = 20;
  localparam int unsigned AmtW = 16;

  // op codes
  localparam logic [2:0] OP_LOAD_FREE  = 3'd0;
  localparam logic [2:0] OP_LOAD_HELD  = 3'd1;
  localparam logic [2:0] OP_LOAD_CLAIM = 3'd2;
  localparam logic [2:0] OP_CHECK      = 3'd3;
  localparam logic [2:0] OP_REQUEST    = 3'd4;

  // result status codes
  localparam logic [2:0] ST_LOADED     = 3'd0;
  localparam logic [2:0] ST_SAFE       = 3'd1;
  localparam logic [2:0] ST_UNSAFE     = 3'd2;
  localparam logic [2:0] ST_GRANTED    = 3'd3;
  localparam logic [2:0] ST_OVER_CLAIM = 3'd4;
  localparam logic [2:0] ST_MUST_WAIT  = 3'd5;
  localparam logic [2:0] ST_DENIED     = 3'd6;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd7;

  // configuration register indexes
  localparam logic CFG_ACTIVE_PROCESSES = 1'b0;
  localparam logic CFG_ACTIVE_RESOURCES = 1'b1;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      proc;
    logic [AmtW-1:0] amount_0;
    logic [AmtW-1:0] amount_1;
    logic [AmtW-1:0] amount_2;
    logic [AmtW-1:0] amount_3;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_proc;
    logic       last;
  } out_item_t;

  // per-lane compare results
  typedef struct packed {
    logic fits;
    logic over;
    logic lack;
  } lane_flags_t;

  // merged compare results over all lanes
  typedef struct packed {
    logic fits_all;
    logic any_over;
    logic any_lack;
  } merge_flags_t;

endpackage

@@ design/darg_lane.sv @@
module darg_lane (
  input  logic                          en_i,
  input  logic [darg_pkg::AmtW-1:0]     claim_i,
  input  logic [darg_pkg::AmtW-1:0]     held_i,
  input  logic [darg_pkg::AmtW-1:0]     amt_i,
  input  logic [darg_pkg::AmtW-1:0]     free_i,
  input  logic [darg_pkg::WorkW-1:0]    work_i,
  output darg_pkg::lane_flags_t         flags_o
);
  import darg_pkg::*;

  logic signed [AmtW:0] need;

  // need is claim minus held, signed
  assign need = $signed({1'b0, claim_i}) - $signed({1'b0, held_i});

  // unused lanes never block and never flag
  assign flags_o.fits = !en_i || (need <= $signed({1'b0, work_i}));
  assign flags_o.over = en_i && ($signed({1'b0, amt_i}) > need);
  assign flags_o.lack = en_i && (amt_i > free_i);

endmodule

@@ design/darg_merge.sv @@
module darg_merge #(
  parameter int unsigned RESOURCES = 4
) (
  input  darg_pkg::lane_flags_t  lanes_i [RESOURCES],
  output darg_pkg::merge_flags_t merged_o
);
  import darg_pkg::*;

  // and/or reduction over the lanes
  always_comb begin
    merged_o.fits_all = 1'b1;
    merged_o.any_over = 1'b0;
    merged_o.any_lack = 1'b0;
    for (int j = 0; j < RESOURCES; j++) begin
      merged_o.fits_all = merged_o.fits_all & lanes_i[j].fits;
      merged_o.any_over = merged_o.any_over | lanes_i[j].over;
      merged_o.any_lack = merged_o.any_lack | lanes_i[j].lack;
    end
  end

endmodule

@@ design/deadlock_avoiding_resource_grant.sv @@
// Banker's algorithm engine. Each accepted beat is handled alone. A safety check or a
// granted request scans one process row per cycle through RESOURCES compare lanes, over np
// active processes (at most 8). A safe check or grant returns np beats, the last one
// flagged; every other op returns a single beat, and op codes 5 to 7 return nothing. The
// result register lets the next input beat be taken while a result beat still waits on
// out_ready_i.
module deadlock_avoiding_resource_grant #(
  parameter int unsigned PROCESSES = 8,
  parameter int unsigned RESOURCES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  darg_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output darg_pkg::out_item_t out_data_o
);
  import darg_pkg::*;

  localparam int unsigned IdxW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned Cap  = (PROCESSES < MaxSeq) ? PROCESSES : MaxSeq;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT,
    S_RESP
  } state_e;

  state_e          state_q;
  logic [3:0]      act_proc_q;
  logic [2:0]      act_res_q;
  in_item_t        in_q;
  logic            is_req_q;
  logic [2:0]      resp_q;
  logic [AmtW-1:0] free_q  [RESOURCES];
  logic [AmtW-1:0] held_q  [PROCESSES][RESOURCES];
  logic [AmtW-1:0] claim_q [PROCESSES][RESOURCES];
  logic [WorkW-1:0] work_q [RESOURCES];
  logic [MaxSeq-1:0] done_q;
  logic [2:0]      seq_q [MaxSeq];
  logic [3:0]      count_q;
  logic [2:0]      p_q;
  logic            found_q;
  logic [2:0]      emit_q;
  logic            out_valid_q;
  out_item_t       out_q;

  logic [3:0]      np;
  logic [2:0]      nr;
  logic [AmtW-1:0] amt [4];
  logic [IdxW-1:0] rd_row;
  logic [IdxW-1:0] proc_row;
  lane_flags_t     lanes [RESOURCES];
  merge_flags_t    merged;
  logic            slot_free;
  logic            out_load;
  logic            take;
  logic [3:0]      count_n;
  logic            found_n;
  logic            end_pass;
  logic            proc_bad;

  // effective counts from the config registers
  always_comb begin
    if (act_proc_q == 4'd0) begin
      np = 4'd1;
    end else if (act_proc_q > 4'(Cap)) begin
      np = 4'(Cap);
    end else begin
      np = act_proc_q;
    end
    if (act_res_q == 3'd0) begin
      nr = 3'd1;
    end else if (act_res_q > 3'(RESOURCES)) begin
      nr = 3'(RESOURCES);
    end else begin
      nr = act_res_q;
    end
  end

  assign amt[0] = in_q.amount_0;
  assign amt[1] = in_q.amount_1;
  assign amt[2] = in_q.amount_2;
  assign amt[3] = in_q.amount_3;

  assign proc_bad = ({1'b0, in_q.proc} >= np);
  assign proc_row = proc_bad ? '0 : IdxW'(in_q.proc);
  assign rd_row   = (state_q == S_SCAN) ? IdxW'(p_q) : proc_row;

  // compare lanes, one per resource type
  for (genvar j = 0; j < RESOURCES; j++) begin : g_lane
    darg_lane u_lane (
      .en_i    (3'(j) < nr),
      .claim_i (claim_q[rd_row][j]),
      .held_i  (held_q[rd_row][j]),
      .amt_i   (amt[j]),
      .free_i  (free_q[j]),
      .work_i  (work_q[j]),
      .flags_o (lanes[j])
    );
  end

  darg_merge #(
    .RESOURCES (RESOURCES)
  ) u_merge (
    .lanes_i  (lanes),
    .merged_o (merged)
  );

  // scan step bookkeeping
  assign take     = !done_q[p_q] && merged.fits_all;
  assign count_n  = count_q + {3'd0, take};
  assign found_n  = found_q | take;
  assign end_pass = ({1'b0, p_q} == np - 4'd1);
  assign slot_free = !out_valid_q || out_ready_i;
  assign out_load  = ((state_q == S_EMIT) || (state_q == S_RESP)) && slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control, storage and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_proc_q  <= 4'd8;
      act_res_q   <= 3'd4;
      in_q        <= '0;
      is_req_q    <= 1'b0;
      resp_q      <= ST_LOADED;
      done_q      <= '0;
      count_q     <= '0;
      p_q         <= '0;
      found_q     <= 1'b0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int j = 0; j < RESOURCES; j++) begin
        free_q[j] <= '0;
        work_q[j] <= '0;
      end
      for (int i = 0; i < PROCESSES; i++) begin
        for (int j = 0; j < RESOURCES; j++) begin
          held_q[i][j]  <= '0;
          claim_q[i][j] <= '0;
        end
      end
      for (int i = 0; i < MaxSeq; i++) begin
        seq_q[i] <= '0;
      end
    end else begin
      // config writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACTIVE_PROCESSES) begin
          act_proc_q <= cfg_data_i;
        end else begin
          act_res_q <= cfg_data_i[2:0];
        end
      end

      // result beat loaded or taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          done_q  <= '0;
          count_q <= '0;
          p_q     <= '0;
          found_q <= 1'b0;
          emit_q  <= '0;
          case (in_q.op)
            OP_LOAD_FREE: begin
              for (int j = 0; j < RESOURCES; j++) begin
                free_q[j] <= amt[j];
              end
              resp_q  <= ST_LOADED;
              state_q <= S_RESP;
            end
            OP_CHECK: begin
              for (int j = 0; j < RESOURCES; j++) begin
                work_q[j] <= WorkW'(free_q[j]);
              end
              is_req_q <= 1'b0;
              state_q  <= S_SCAN;
            end
            OP_LOAD_HELD, OP_LOAD_CLAIM: begin
              if (proc_bad) begin
                resp_q <= ST_BAD_INDEX;
              end else begin
                for (int j = 0; j < RESOURCES; j++) begin
                  if (in_q.op == OP_LOAD_HELD) begin
                    held_q[proc_row][j] <= amt[j];
                  end else begin
                    claim_q[proc_row][j] <= amt[j];
                  end
                end
                resp_q <= ST_LOADED;
              end
              state_q <= S_RESP;
            end
            OP_REQUEST: begin
              if (proc_bad) begin
                resp_q  <= ST_BAD_INDEX;
                state_q <= S_RESP;
              end else if (merged.any_over) begin
                resp_q  <= ST_OVER_CLAIM;
                state_q <= S_RESP;
              end else if (merged.any_lack) begin
                resp_q  <= ST_MUST_WAIT;
                state_q <= S_RESP;
              end else begin
                // try the grant, then scan
                for (int j = 0; j < RESOURCES; j++) begin
                  if (3'(j) < nr) begin
                    free_q[j]           <= free_q[j] - amt[j];
                    held_q[proc_row][j] <= held_q[proc_row][j] + amt[j];
                    work_q[j]           <= WorkW'(free_q[j] - amt[j]);
                  end else begin
                    work_q[j] <= WorkW'(free_q[j]);
                  end
                end
                is_req_q <= 1'b1;
                state_q  <= S_SCAN;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end

        S_SCAN: begin
          if (take) begin
            for (int j = 0; j < RESOURCES; j++) begin
              work_q[j] <= work_q[j] + WorkW'(held_q[rd_row][j]);
            end
            seq_q[count_q[2:0]] <= p_q;
            done_q[p_q]         <= 1'b1;
          end
          count_q <= count_n;
          if (count_n == np) begin
            state_q <= S_EMIT;
          end else if (end_pass) begin
            p_q     <= '0;
            found_q <= 1'b0;
            if (!found_n) begin
              if (is_req_q) begin
                // roll the trial grant back
                for (int j = 0; j < RESOURCES; j++) begin
                  if (3'(j) < nr) begin
                    free_q[j]           <= free_q[j] + amt[j];
                    held_q[proc_row][j] <= held_q[proc_row][j] - amt[j];
                  end
                end
                resp_q <= ST_DENIED;
              end else begin
                resp_q <= ST_UNSAFE;
              end
              state_q <= S_RESP;
            end
          end else begin
            p_q     <= p_q + 3'd1;
            found_q <= found_n;
          end
        end

        S_EMIT: begin
          if (slot_free) begin
            out_q.status   <= is_req_q ? ST_GRANTED : ST_SAFE;
            out_q.seq_proc <= seq_q[emit_q];
            out_q.last     <= ({1'b0, emit_q} == np - 4'd1);
            emit_q         <= emit_q + 3'd1;
            if ({1'b0, emit_q} == np - 4'd1) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_RESP: begin
          if (slot_free) begin
            out_q.status   <= resp_q;
            out_q.seq_proc <= '0;
            out_q.last     <= 1'b1;
            state_q        <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/darg_checker.sv @@
module darg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input darg_pkg::out_item_t out_data_o
);
  import darg_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // single-beat answers carry last and no sequence entry
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_SAFE && out_data_o.status != ST_GRANTED
    |-> out_data_o.last && out_data_o.seq_proc == 3'd0)
    else $error("single result without last or with sequence entry");

  // the engine is busy right after it takes an input beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous beat in work");

endmodule

bind deadlock_avoiding_resource_grant darg_checker u_darg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
